@@ design/est_pkg.sv @@
// ----------------------------------------------------------------------------
// est_pkg: shared types and codes for the epoch slot table
// Word layouts for the request and result channels, side, action, status and
// configuration register codes.
// ----------------------------------------------------------------------------
package est_pkg;

  localparam int EpochW      = 64;
  localparam int SideW       = 2;
  localparam int SlotOutW    = 2;
  localparam int CfgIdxW     = 1;
  localparam int DefaultSlots = 4;

  // Side codes
  localparam logic [SideW-1:0] SIDE_ENC  = 2'd0;
  localparam logic [SideW-1:0] SIDE_DEC  = 2'd1;
  localparam logic [SideW-1:0] SIDE_BOTH = 2'd2;

  // Action codes
  localparam logic ACT_INSTALL = 1'b0;
  localparam logic ACT_SELECT  = 1'b1;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LOCAL_EPOCH = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_PEER_EPOCH  = 1'd1;

  typedef struct packed {
    logic              action;
    logic [EpochW-1:0] epoch_number;
    logic [SideW-1:0]  side;
  } in_word_t;

  typedef struct packed {
    logic                status;
    logic [SlotOutW-1:0] slot;
    logic [SideW-1:0]    slot_side;
    logic                evicted;
    logic                copy_keys;
    logic                enc_selected_valid;
    logic [SlotOutW-1:0] enc_selected_slot;
    logic                dec_selected_valid;
    logic [SlotOutW-1:0] dec_selected_slot;
  } out_word_t;

endpackage

@@ design/epoch_slot_table.sv @@
// ----------------------------------------------------------------------------
// epoch_slot_table: table of secure-transport epochs
// Install, update and select of epoch slots, with eviction of the oldest
// epoch that is neither the local nor the peer epoch.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 word
//  --------  ------------------------  -------------------------------
//  request   in_valid_i / in_ready_o   in_data_i  (est_pkg::in_word_t)
//  result    out_valid_o / out_ready_i out_data_o (est_pkg::out_word_t)
//  config    cfg_we_i                  cfg_idx_i, cfg_data_i
//
//  One word per cycle while results are taken: a request is registered,
//  then looked up and applied to the table as it leaves the request stage,
//  and its result lands in the output register.
//  Reset clears all slot valid bits, both selections and both epochs.
//  A stalled result holds the request stage; the input stalls only when
//  both stages are full.
//
module epoch_slot_table #(
  parameter int Slots = est_pkg::DefaultSlots
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  est_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output est_pkg::out_word_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [est_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [est_pkg::EpochW-1:0]    cfg_data_i
);

  localparam int IdxW = $clog2(Slots);

  // configuration
  logic [est_pkg::EpochW-1:0] local_epoch_q, peer_epoch_q;

  // table state
  logic [Slots-1:0]                      slot_valid_q;
  logic [Slots-1:0][est_pkg::EpochW-1:0] slot_epoch_q;
  logic [Slots-1:0][est_pkg::SideW-1:0]  slot_side_q;
  logic                                  enc_sel_valid_q, dec_sel_valid_q;
  logic [IdxW-1:0]                       enc_sel_slot_q, dec_sel_slot_q;

  // pipeline
  logic                s1_valid_q;
  est_pkg::in_word_t   s1_q;
  logic                out_valid_q;
  est_pkg::out_word_t  out_q;
  logic                s1_adv, fire;

  // lookup results
  logic [Slots-1:0]    hit_vec;
  logic                hit;
  logic [IdxW-1:0]     hit_idx, free_idx, vic_idx;
  logic                free_any, vic_found;

  // update controls and result
  logic                     bad;
  logic                     upd_en, upd_new;
  logic [IdxW-1:0]          upd_idx;
  logic [est_pkg::SideW-1:0] upd_side, stored_side;
  logic                     evicted, copy_keys;
  logic                     enc_sel_valid_d, dec_sel_valid_d;
  logic [IdxW-1:0]          enc_sel_slot_d, dec_sel_slot_d;
  est_pkg::out_word_t       res;

  // handshake
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign fire       = s1_valid_q && s1_adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_epoch_q <= '0;
      peer_epoch_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        est_pkg::CFG_LOCAL_EPOCH: local_epoch_q <= cfg_data_i;
        est_pkg::CFG_PEER_EPOCH:  peer_epoch_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) s1_q <= in_data_i;
  end

  // match and free-slot search, lowest index first
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      hit_vec[i] = slot_valid_q[i] && (slot_epoch_q[i] == s1_q.epoch_number);
      if (hit_vec[i])       hit_idx  = IdxW'(i);
      if (!slot_valid_q[i]) free_idx = IdxW'(i);
    end
  end

  assign hit         = |hit_vec;
  assign free_any    = ~&slot_valid_q;
  assign stored_side = slot_side_q[hit_idx];

  est_victim #(
    .Slots(Slots)
  ) u_victim (
    .epoch_i       (slot_epoch_q),
    .local_epoch_i (local_epoch_q),
    .peer_epoch_i  (peer_epoch_q),
    .found_o       (vic_found),
    .idx_o         (vic_idx)
  );

  // request decision
  always_comb begin
    bad             = 1'b0;
    upd_en          = 1'b0;
    upd_new         = 1'b0;
    upd_idx         = hit_idx;
    upd_side        = stored_side;
    evicted         = 1'b0;
    copy_keys       = 1'b0;
    enc_sel_valid_d = enc_sel_valid_q;
    enc_sel_slot_d  = enc_sel_slot_q;
    dec_sel_valid_d = dec_sel_valid_q;
    dec_sel_slot_d  = dec_sel_slot_q;
    if (s1_q.side > est_pkg::SIDE_BOTH) begin
      bad = 1'b1;
    end else if (s1_q.action == est_pkg::ACT_INSTALL) begin
      if (hit) begin
        upd_en   = 1'b1;
        upd_side = (stored_side != s1_q.side) ? est_pkg::SIDE_BOTH : stored_side;
      end else if (free_any) begin
        upd_en   = 1'b1;
        upd_new  = 1'b1;
        upd_idx  = free_idx;
        upd_side = s1_q.side;
      end else if (vic_found) begin
        upd_en   = 1'b1;
        upd_new  = 1'b1;
        upd_idx  = vic_idx;
        upd_side = s1_q.side;
        evicted  = 1'b1;
      end else begin
        bad = 1'b1;
      end
      copy_keys = !bad;
    end else begin
      if (!hit || (stored_side != est_pkg::SIDE_BOTH && stored_side != s1_q.side)) begin
        bad = 1'b1;
      end else begin
        if (s1_q.side == est_pkg::SIDE_ENC || s1_q.side == est_pkg::SIDE_BOTH) begin
          enc_sel_valid_d = 1'b1;
          enc_sel_slot_d  = hit_idx;
        end
        if (s1_q.side == est_pkg::SIDE_DEC || s1_q.side == est_pkg::SIDE_BOTH) begin
          dec_sel_valid_d = 1'b1;
          dec_sel_slot_d  = hit_idx;
        end
        copy_keys = (s1_q.epoch_number != '0);
      end
    end
  end

  // result word
  always_comb begin
    res.status             = bad ? est_pkg::STATUS_BAD : est_pkg::STATUS_OK;
    res.slot               = bad ? '0 : est_pkg::SlotOutW'(upd_idx);
    res.slot_side          = bad ? '0 : upd_side;
    res.evicted            = evicted;
    res.copy_keys          = copy_keys;
    res.enc_selected_valid = enc_sel_valid_d;
    res.enc_selected_slot  = est_pkg::SlotOutW'(enc_sel_slot_d);
    res.dec_selected_valid = dec_sel_valid_d;
    res.dec_selected_slot  = est_pkg::SlotOutW'(dec_sel_slot_d);
  end

  // table and selection update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q    <= '0;
      slot_epoch_q    <= '0;
      slot_side_q     <= '0;
      enc_sel_valid_q <= 1'b0;
      enc_sel_slot_q  <= '0;
      dec_sel_valid_q <= 1'b0;
      dec_sel_slot_q  <= '0;
    end else if (fire) begin
      if (upd_en) begin
        slot_side_q[upd_idx] <= upd_side;
        if (upd_new) begin
          slot_valid_q[upd_idx] <= 1'b1;
          slot_epoch_q[upd_idx] <= s1_q.epoch_number;
        end
      end
      enc_sel_valid_q <= enc_sel_valid_d;
      enc_sel_slot_q  <= enc_sel_slot_d;
      dec_sel_valid_q <= dec_sel_valid_d;
      dec_sel_slot_q  <= dec_sel_slot_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= res;
  end

  // checks
  a_bad_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == est_pkg::STATUS_BAD |->
      out_data_o.slot == '0 && !out_data_o.evicted && !out_data_o.copy_keys)
    else $error("bad-state result carries slot data");

  a_evict_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.evicted |->
      out_data_o.status == est_pkg::STATUS_OK && out_data_o.copy_keys)
    else $error("eviction without successful install");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q))
    else $error("request stage overwritten while stalled");

  a_sel_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc_sel_valid_q && dec_sel_valid_q |=> enc_sel_valid_q && dec_sel_valid_q)
    else $error("selection dropped");

endmodule

@@ design/est_victim.sv @@
// ----------------------------------------------------------------------------
// est_victim: eviction candidate pick
// Finds the slot with the smallest epoch that is neither the local nor the
// peer epoch; ties go to the lowest index. Parallel pairwise compare.
// ----------------------------------------------------------------------------
module est_victim #(
  parameter int Slots = est_pkg::DefaultSlots
) (
  input  logic [Slots-1:0][est_pkg::EpochW-1:0] epoch_i,
  input  logic [est_pkg::EpochW-1:0]            local_epoch_i,
  input  logic [est_pkg::EpochW-1:0]            peer_epoch_i,
  output logic                                  found_o,
  output logic [$clog2(Slots)-1:0]              idx_o
);

  localparam int IdxW = $clog2(Slots);

  logic [Slots-1:0] cand;
  logic [Slots-1:0] win;

  // slots that may be evicted at all
  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      cand[i] = (epoch_i[i] != local_epoch_i) && (epoch_i[i] != peer_epoch_i);
    end
  end

  // slot i wins if it beats every other candidate; lower index wins a tie
  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      win[i] = cand[i];
      for (int j = 0; j < Slots; j++) begin
        if (j < i) begin
          if (cand[j] && !(epoch_i[i] < epoch_i[j])) win[i] = 1'b0;
        end else if (j > i) begin
          if (cand[j] && (epoch_i[i] > epoch_i[j])) win[i] = 1'b0;
        end
      end
    end
  end

  // winner is one-hot: OR-encode
  always_comb begin
    idx_o = '0;
    for (int i = 0; i < Slots; i++) begin
      if (win[i]) idx_o = idx_o | IdxW'(i);
    end
  end

  assign found_o = |cand;

endmodule
